// ===== rtl/core/periodic_image_cell_binner_macros.svh =====
// Assertion macros shared by the periodic image cell binner RTL.
`ifndef PERIODIC_IMAGE_CELL_BINNER_MACROS_SVH
`define PERIODIC_IMAGE_CELL_BINNER_MACROS_SVH
// Same-cycle implication, reset-gated.
`define PICB_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, reset-gated.
`define PICB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/picb_pkg.sv =====
// Shared types and constants for the periodic image cell binner.
package picb_pkg;
  localparam int unsigned SPAN_W    = 31;
  localparam int unsigned CELLS_W   = 6;
  localparam int unsigned BIN_W     = 7;
  localparam int unsigned TIDX_W    = 14;
  localparam int unsigned CELL_W    = 18;
  localparam int unsigned QUOT_W    = 6;
  localparam int unsigned DIV_W     = 37;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_AXES  = 3;

  localparam logic [SPAN_W-1:0]  SPAN_RST  = 31'd65536;
  localparam logic [SPAN_W-1:0]  LAYER_RST = 31'd65536;
  localparam logic [CELLS_W-1:0] CELLS_RST = 6'd1;
  localparam logic [CELLS_W-1:0] FACES_RST = 6'd0;
  localparam logic [2:0]         LAST_STEP = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPAN_X  = 3'd0,
    CFG_SPAN_Y  = 3'd1,
    CFG_SPAN_Z  = 3'd2,
    CFG_LAYER   = 3'd3,
    CFG_CELLS_X = 3'd4,
    CFG_CELLS_Y = 3'd5,
    CFG_CELLS_Z = 3'd6,
    CFG_FACES   = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SH_NONE  = 2'd0,
    SH_PLUS  = 2'd1,
    SH_MINUS = 2'd2
  } shift_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LAYER,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_IDX1,
    ST_IDX2,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic       load;
    logic       layer;
    logic       prep;
    logic       mul;
    logic       step;
    logic       fin;
    logic       idx1;
    logic       idx2;
    logic       emit;
    logic       advance;
    logic [1:0] axis;
    logic [2:0] bit_sel;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic last;
  } status_t;
endpackage

// ===== rtl/core/picb_ctrl.sv =====
// Sequencer for the periodic image cell binner.
`include "periodic_image_cell_binner_macros.svh"
module picb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  picb_pkg::status_t status_i,
  output picb_pkg::cmd_t    cmd_o
);
  import picb_pkg::*;

  state_e     state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic [2:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q  <= 2'd0;
      step_q  <= 3'd0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    axis_d        = axis_q;
    step_d        = step_q;
    cmd_o         = '0;
    cmd_o.axis    = axis_q;
    cmd_o.bit_sel = step_q;
    in_ready_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LAYER;
        end
      end
      ST_LAYER: begin
        cmd_o.layer = 1'b1;
        state_d     = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        axis_d     = 2'd0;
        state_d    = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        step_d    = LAST_STEP;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (step_q == 3'd0) begin
          state_d = ST_FIN;
        end else begin
          step_d = step_q - 3'd1;
        end
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        if (axis_q == 2'd2) begin
          state_d = ST_IDX1;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = ST_MUL;
        end
      end
      ST_IDX1: begin
        cmd_o.idx1 = 1'b1;
        state_d    = ST_IDX2;
      end
      ST_IDX2: begin
        cmd_o.idx2 = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = ST_PREP;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `PICB_ASSERT_IMPLY(a_step_range, clk_i, rst_ni, state_q == ST_DIV, step_q <= LAST_STEP)
  `PICB_ASSERT_IMPLY(a_axis_range, clk_i, rst_ni, cmd_o.mul || cmd_o.fin, axis_q != 2'd3)
  `PICB_ASSERT_IMPLY(a_emit_free, clk_i, rst_ni, cmd_o.emit, status_i.out_free)
  `PICB_ASSERT_NEXT(a_busy_after_load, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
endmodule

// ===== rtl/core/picb_datapath.sv =====
// Config registers, image shifter, shared restoring divider and output register.
module picb_datapath #(
  parameter int unsigned MAX_CELLS_PER_AXIS = 62,
  parameter int unsigned POS_WIDTH          = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [picb_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [picb_pkg::SPAN_W-1:0]         cfg_wdata_i,
  input  logic signed [POS_WIDTH-1:0]         pos_x_i,
  input  logic signed [POS_WIDTH-1:0]         pos_y_i,
  input  logic signed [POS_WIDTH-1:0]         pos_z_i,
  input  picb_pkg::cmd_t                      cmd_i,
  output picb_pkg::status_t                   status_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [POS_WIDTH-1:0]         out_x_o,
  output logic signed [POS_WIDTH-1:0]         out_y_o,
  output logic signed [POS_WIDTH-1:0]         out_z_o,
  output logic [picb_pkg::CELL_W-1:0]         cell_index_o,
  output logic                                is_image_o,
  output logic                                last_o
);
  import picb_pkg::*;

  localparam int unsigned XW = ((POS_WIDTH > 32) ? POS_WIDTH : 32) + 2;
  localparam logic signed [XW-1:0] PMAX =
    {{(XW-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
  localparam logic signed [XW-1:0] PMIN = ~PMAX;

  // config registers
  logic [SPAN_W-1:0]  span_q [NUM_AXES];
  logic [SPAN_W-1:0]  layer_q;
  logic [CELLS_W-1:0] cells_q [NUM_AXES];
  logic [CELLS_W-1:0] faces_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        span_q[a]  <= SPAN_RST;
        cells_q[a] <= CELLS_RST;
      end
      layer_q <= LAYER_RST;
      faces_q <= FACES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SPAN_X:  span_q[0]  <= cfg_wdata_i;
        CFG_SPAN_Y:  span_q[1]  <= cfg_wdata_i;
        CFG_SPAN_Z:  span_q[2]  <= cfg_wdata_i;
        CFG_LAYER:   layer_q    <= cfg_wdata_i;
        CFG_CELLS_X: cells_q[0] <= cfg_wdata_i[CELLS_W-1:0];
        CFG_CELLS_Y: cells_q[1] <= cfg_wdata_i[CELLS_W-1:0];
        CFG_CELLS_Z: cells_q[2] <= cfg_wdata_i[CELLS_W-1:0];
        CFG_FACES:   faces_q    <= cfg_wdata_i[CELLS_W-1:0];
        default: ;
      endcase
    end
  end

  // effective span and cell count
  logic [SPAN_W-1:0]    span_e  [NUM_AXES];
  logic [CELLS_W-1:0]   cells_e [NUM_AXES];
  logic signed [XW-1:0] span_s  [NUM_AXES];
  logic signed [XW-1:0] layer_s;

  always_comb begin
    layer_s = $signed({{(XW-SPAN_W){1'b0}}, layer_q});
    for (int a = 0; a < NUM_AXES; a++) begin
      span_e[a] = (span_q[a] == '0) ? SPAN_W'(1) : span_q[a];
      span_s[a] = $signed({{(XW-SPAN_W){1'b0}}, span_e[a]});
      if (cells_q[a] == '0) begin
        cells_e[a] = CELLS_W'(1);
      end else if (32'(cells_q[a]) > MAX_CELLS_PER_AXIS) begin
        cells_e[a] = CELLS_W'(MAX_CELLS_PER_AXIS);
      end else begin
        cells_e[a] = cells_q[a];
      end
    end
  end

  // particle and image state
  logic signed [XW-1:0] p_q [NUM_AXES];
  logic signed [XW-1:0] q_q [NUM_AXES];
  logic [NUM_AXES-1:0]  hit_min_q, hit_max_q;
  logic                 inside_q;
  logic                 in_dom;
  shift_e               code_q [NUM_AXES];
  shift_e               code_n [NUM_AXES];
  logic                 has_next;

  // particle within [0, span] on every axis
  always_comb begin
    in_dom = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (p_q[a] < 0 || p_q[a] > span_s[a]) in_dom = 1'b0;
    end
  end

  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int a = NUM_AXES - 1; a >= 0; a--) begin
      code_n[a] = code_q[a];
      if (carry) begin
        carry = 1'b0;
        unique case (code_q[a])
          SH_NONE: begin
            if (hit_min_q[a])      code_n[a] = SH_PLUS;
            else if (hit_max_q[a]) code_n[a] = SH_MINUS;
            else begin
              code_n[a] = SH_NONE;
              carry     = 1'b1;
            end
          end
          SH_PLUS: begin
            if (hit_max_q[a]) code_n[a] = SH_MINUS;
            else begin
              code_n[a] = SH_NONE;
              carry     = 1'b1;
            end
          end
          default: begin
            code_n[a] = SH_NONE;
            carry     = 1'b1;
          end
        endcase
      end
    end
    has_next = !carry;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      p_q[0] <= {{(XW-POS_WIDTH){pos_x_i[POS_WIDTH-1]}}, pos_x_i};
      p_q[1] <= {{(XW-POS_WIDTH){pos_y_i[POS_WIDTH-1]}}, pos_y_i};
      p_q[2] <= {{(XW-POS_WIDTH){pos_z_i[POS_WIDTH-1]}}, pos_z_i};
    end
    if (cmd_i.layer) begin
      inside_q <= in_dom;
      for (int a = 0; a < NUM_AXES; a++) begin
        hit_min_q[a] <= faces_q[2*a] && (p_q[a] < layer_s);
        hit_max_q[a] <= faces_q[2*a+1] && (p_q[a] >= span_s[a] - layer_s);
        code_q[a]    <= SH_NONE;
      end
    end else if (cmd_i.advance) begin
      for (int a = 0; a < NUM_AXES; a++) code_q[a] <= code_n[a];
    end
    if (cmd_i.prep) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        unique case (code_q[a])
          SH_PLUS:  q_q[a] <= p_q[a] + span_s[a];
          SH_MINUS: q_q[a] <= p_q[a] - span_s[a];
          default:  q_q[a] <= p_q[a];
        endcase
      end
    end
  end

  // shared restoring divider, six quotient bits (quotient never exceeds cells)
  logic [DIV_W-1:0]     rem_q;
  logic [QUOT_W-1:0]    quot_q;
  logic                 direct_q;
  logic [BIN_W-1:0]     dval_q;
  logic [BIN_W-1:0]     bin_q [NUM_AXES];
  logic signed [XW-1:0] qa;
  logic [SPAN_W-1:0]    sa;
  logic [CELLS_W-1:0]   ca;
  logic [DIV_W-1:0]     trial;
  logic [BIN_W-1:0]     q_plus;

  always_comb begin
    qa     = q_q[cmd_i.axis];
    sa     = span_e[cmd_i.axis];
    ca     = cells_e[cmd_i.axis];
    trial  = DIV_W'(sa) << cmd_i.bit_sel;
    q_plus = BIN_W'(quot_q) + BIN_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      quot_q <= '0;
      rem_q  <= DIV_W'(qa[SPAN_W-1:0]) * DIV_W'(ca);
      if (qa < 0) begin
        direct_q <= 1'b1;
        dval_q   <= '0;
      end else if (qa > $signed({{(XW-SPAN_W){1'b0}}, sa})) begin
        direct_q <= 1'b1;
        dval_q   <= BIN_W'(ca) + BIN_W'(1);
      end else begin
        direct_q <= 1'b0;
        dval_q   <= '0;
      end
    end
    if (cmd_i.step && rem_q >= trial) begin
      rem_q                  <= rem_q - trial;
      quot_q[cmd_i.bit_sel]  <= 1'b1;
    end
    if (cmd_i.fin) begin
      if (direct_q)                    bin_q[cmd_i.axis] <= dval_q;
      else if (q_plus > BIN_W'(ca))    bin_q[cmd_i.axis] <= BIN_W'(ca);
      else                             bin_q[cmd_i.axis] <= q_plus;
    end
  end

  // linear cell index in two multiply stages
  logic [TIDX_W-1:0] t_q;
  logic [CELL_W-1:0] cell_q;
  logic [2*TIDX_W-1:0] prod2;

  assign prod2 = (2*TIDX_W)'(BIN_W'(cells_e[0]) + BIN_W'(2)) * (2*TIDX_W)'(t_q)
               + (2*TIDX_W)'(bin_q[0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.idx1) begin
      t_q <= TIDX_W'(bin_q[1]) +
             TIDX_W'(BIN_W'(cells_e[1]) + BIN_W'(2)) * TIDX_W'(bin_q[2]);
    end
    if (cmd_i.idx2) cell_q <= prod2[CELL_W-1:0];
  end

  // saturate image coordinates
  function automatic logic [POS_WIDTH-1:0] sat(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    if (v > PMAX)      r = PMAX;
    else if (v < PMIN) r = PMIN;
    else               r = v;
    return r[POS_WIDTH-1:0];
  endfunction

  // output register
  logic out_valid_q;
  logic is_first;
  logic last_now;

  assign is_first = (code_q[0] == SH_NONE) && (code_q[1] == SH_NONE) &&
                    (code_q[2] == SH_NONE);
  assign last_now = !inside_q || !has_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_x_o      <= sat(q_q[0]);
      out_y_o      <= sat(q_q[1]);
      out_z_o      <= sat(q_q[2]);
      cell_index_o <= cell_q;
      is_image_o   <= !is_first;
      last_o       <= last_now;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.last     = last_now;
endmodule

// ===== rtl/core/periodic_image_cell_binner.sv =====
// Top level of the periodic image cell binner: sequencer plus datapath.
// Each result runs one shift step, then for each of three axes one multiply,
//   six restoring-divider steps and one finish, then two index steps and one emit.
// An item yields 1 to 27 results.
// One item is in work at a time; the next is taken once the last result is in
//   the output register. Reset (rst_ni low, async) returns config to defaults.
module periodic_image_cell_binner #(
  parameter int unsigned MAX_CELLS_PER_AXIS = 62,
  parameter int unsigned POS_WIDTH          = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [picb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [picb_pkg::SPAN_W-1:0]    cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [POS_WIDTH-1:0]    pos_x_i,
  input  logic signed [POS_WIDTH-1:0]    pos_y_i,
  input  logic signed [POS_WIDTH-1:0]    pos_z_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [POS_WIDTH-1:0]    out_x_o,
  output logic signed [POS_WIDTH-1:0]    out_y_o,
  output logic signed [POS_WIDTH-1:0]    out_z_o,
  output logic [picb_pkg::CELL_W-1:0]    cell_index_o,
  output logic                           is_image_o,
  output logic                           last_o
);
  import picb_pkg::*;

  // command and status between sequencer and datapath
  cmd_t    cmd;
  status_t status;

  picb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath holds config, divider and the output register for each transfer
  picb_datapath #(
    .MAX_CELLS_PER_AXIS (MAX_CELLS_PER_AXIS),
    .POS_WIDTH          (POS_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_z_o      (out_z_o),
    .cell_index_o (cell_index_o),
    .is_image_o   (is_image_o),
    .last_o       (last_o)
  );
endmodule
